// ===== hw/rtl/mi3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants, types and tables for the 3x3 matrix inverse block.
// ----------------------------------------------------------------------------
package mi3_pkg;

    // default element format: signed Q16.16
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // elements per matrix and issue index width
    localparam int NUM_ELEM = 9;
    localparam int IDX_W    = $clog2(NUM_ELEM);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEM - 1);

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SING = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // cofactor k = a[p]*a[q] - a[r]*a[s], already transposed into output order
    localparam logic [3:0] COF_IDX [0:NUM_ELEM-1][0:3] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    // side info that rides with one element through the divider
    typedef struct packed {
        logic neg;   // quotient sign
        logic last;  // last element of a matrix
        logic sing;  // matrix is singular
    } mi3_tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/matrix_inverse_3x3.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 fixed-point matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// One beat in is one 3x3 matrix of signed fixed-point elements; one beat out
// is its inverse in the same format plus a status code (ok, singular with
// all-zero elements, or saturated). Each element is the exact cofactor over
// determinant quotient truncated toward zero. The single pipelined divider
// takes one element per cycle while the output queue is not full or is being
// read, so nine elements set the pace: a new matrix is taken only once the
// gap counter has let the nine elements of the previous one issue.
// A stalled output holds up to two finished results before input stops.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 import mi3_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // a00 a01 a02 a10 a11 a12 a20 a21 a22, zero pad
    input  wire logic [((NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // b00 b01 b02 b10 b11 b12 b20 b21 b22 status, zero pad
    output logic [((NUM_ELEM*ELEM_WIDTH+2+7)/8)*8-1:0]    m_tdata
);
    localparam int W   = ELEM_WIDTH;
    localparam int PW  = 2 * W;
    localparam int CW  = 2 * W + 1;
    localparam int DTW = 3 * W + 2;
    localparam int DMW = 3 * W + 1;
    localparam int NW  = 2 * W + 2 * FRAC_BITS;
    localparam int RW  = NUM_ELEM * W + 2;

    logic adv, accept;
    logic signed [W-1:0]  a_in [NUM_ELEM];
    logic [IDX_W-1:0]     gap_reg;
    logic [5:1]           v_reg;

    // unpack input beat
    for (genvar k = 0; k < NUM_ELEM; k++) begin : g_unpack
        assign a_in[k] = $signed(s_tdata[k*W +: W]);
    end

    assign s_tready = adv && (gap_reg == LAST_IDX);
    assign accept   = s_tvalid && s_tready;

    // gap counter spaces matrices for their nine element issues, valid shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= LAST_IDX;
            v_reg   <= '0;
        end else if (adv) begin
            if (accept) gap_reg <= '0;
            else if (gap_reg != LAST_IDX) gap_reg <= gap_reg + 1'b1;
            v_reg <= {v_reg[4:1], accept};
        end
    end

    // cofactor lanes
    logic signed [CW-1:0] cof [NUM_ELEM];
    for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
        mi3_lane #(.ELEM_W(W)) u_lane (
            .aclk (aclk),
            .en   (adv),
            .p    (a_in[COF_IDX[k][0]]),
            .q    (a_in[COF_IDX[k][1]]),
            .r    (a_in[COF_IDX[k][2]]),
            .s    (a_in[COF_IDX[k][3]]),
            .cof  (cof[k])
        );
    end

    // first row delayed to meet the cofactors, cofactors delayed to meet det
    logic signed [W-1:0]  a_s1_reg  [3];
    logic signed [W-1:0]  a_s2_reg  [3];
    logic signed [CW-1:0] cof_s3_reg [NUM_ELEM];
    logic signed [CW-1:0] cof_s4_reg [NUM_ELEM];
    logic signed [CW-1:0] cof_s5_reg [NUM_ELEM];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                a_s1_reg[k] <= a_in[k];
                a_s2_reg[k] <= a_s1_reg[k];
            end
            for (int k = 0; k < NUM_ELEM; k++) begin
                cof_s3_reg[k] <= cof[k];
                cof_s4_reg[k] <= cof_s3_reg[k];
                cof_s5_reg[k] <= cof_s4_reg[k];
            end
        end
    end

    // determinant merge
    logic signed [CW-1:0]  det_c [3];
    logic signed [DTW-1:0] det;
    assign det_c[0] = cof[0];
    assign det_c[1] = cof[3];
    assign det_c[2] = cof[6];
    mi3_det #(.ELEM_W(W)) u_det (
        .aclk (aclk),
        .en   (adv),
        .a    (a_s2_reg),
        .c    (det_c),
        .det  (det)
    );

    // hold stage, issues one element per advancing cycle
    logic signed [CW-1:0] hold_cof_reg [NUM_ELEM];
    logic [DMW-1:0]       hold_dmag_reg;
    logic                 hold_dneg_reg, hold_sing_reg, hold_v_reg;
    logic [IDX_W-1:0]     idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            idx_reg    <= '0;
        end else if (adv) begin
            if (v_reg[5]) begin
                hold_v_reg <= 1'b1;
                idx_reg    <= '0;
            end else if (hold_v_reg) begin
                hold_v_reg <= idx_reg != LAST_IDX;
                idx_reg    <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v_reg[5]) begin
            for (int k = 0; k < NUM_ELEM; k++) hold_cof_reg[k] <= cof_s5_reg[k];
            hold_dmag_reg <= DMW'(det[DTW-1] ? -det : det);
            hold_dneg_reg <= det[DTW-1];
            hold_sing_reg <= det == '0;
        end
    end

    logic signed [CW-1:0] cof_sel;
    logic [PW-1:0]        cof_mag;
    logic [NW-1:0]        div_num;
    mi3_tag_t             issue_tag;
    always_comb begin
        cof_sel        = hold_cof_reg[idx_reg];
        cof_mag        = PW'(cof_sel[CW-1] ? -cof_sel : cof_sel);
        div_num        = NW'(cof_mag) << (2 * FRAC_BITS);
        issue_tag.neg  = cof_sel[CW-1] ^ hold_dneg_reg;
        issue_tag.last = idx_reg == LAST_IDX;
        issue_tag.sing = hold_sing_reg;
    end

    // shared divider
    logic          div_v, div_big;
    logic [W-1:0]  div_q;
    mi3_tag_t      div_tag;
    mi3_div #(.ELEM_W(W), .FRAC_B(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_v    (hold_v_reg),
        .num     (div_num),
        .den     (hold_dmag_reg),
        .in_tag  (issue_tag),
        .out_v   (div_v),
        .quo     (div_q),
        .big     (div_big),
        .out_tag (div_tag)
    );

    // result assembly and output queue
    logic [RW-1:0] res;
    mi3_collect #(.ELEM_W(W)) u_collect (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_v     (div_v),
        .quo      (div_q),
        .big      (div_big),
        .tag      (div_tag),
        .adv      (adv),
        .out_v    (m_tvalid),
        .out_rdy  (m_tready),
        .out_data (res)
    );

    always_comb begin
        m_tdata        = '0;
        m_tdata[RW-1:0] = res;
    end

    // checks
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("matrix accepted too soon after previous");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && v_reg[5] && hold_v_reg |-> idx_reg == LAST_IDX)
        else $error("hold stage overwritten before issue completed");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res[RW-1 -: 2] == ST_SING |-> res[RW-3:0] == '0)
        else $error("singular result with nonzero elements");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res[RW-1 -: 2] == ST_OK || res[RW-1 -: 2] == ST_SING ||
                      res[RW-1 -: 2] == ST_SAT))
        else $error("bad status code");
endmodule
`default_nettype wire

// ===== hw/rtl/mi3_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_lane
// One cofactor lane: p*q - r*s, two register stages.
// ----------------------------------------------------------------------------
module mi3_lane import mi3_pkg::*; #(
    parameter int ELEM_W = ELEM_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [ELEM_W-1:0] p,
    input  wire logic signed [ELEM_W-1:0] q,
    input  wire logic signed [ELEM_W-1:0] r,
    input  wire logic signed [ELEM_W-1:0] s,
    output logic signed [2*ELEM_W:0]      cof
);
    localparam int PW = 2 * ELEM_W;
    localparam int CW = 2 * ELEM_W + 1;

    logic signed [PW-1:0] pq_reg, rs_reg;
    logic signed [CW-1:0] cof_reg;

    // products, then difference
    always_ff @(posedge aclk) begin
        if (en) begin
            pq_reg  <= PW'(p) * PW'(q);
            rs_reg  <= PW'(r) * PW'(s);
            cof_reg <= CW'(pq_reg) - CW'(rs_reg);
        end
    end

    assign cof = cof_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/mi3_det.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_det
// Merges first-row elements with their cofactors into the determinant.
// ----------------------------------------------------------------------------
module mi3_det import mi3_pkg::*; #(
    parameter int ELEM_W = ELEM_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [ELEM_W-1:0] a   [3],
    input  wire logic signed [2*ELEM_W:0] c   [3],
    output logic signed [3*ELEM_W+1:0]    det
);
    localparam int PPW = 2 * ELEM_W + 2;
    localparam int DTW = 3 * ELEM_W + 2;

    logic signed [PPW-1:0] pl_reg [3];
    logic signed [PPW-1:0] ph_reg [3];
    logic signed [DTW-1:0] t_reg  [3];
    logic signed [DTW-1:0] det_reg;

    // cofactor split in a low unsigned half and a high signed half
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pl_reg[k] <= PPW'(a[k]) * PPW'($signed({1'b0, c[k][ELEM_W-1:0]}));
                ph_reg[k] <= PPW'(a[k]) * PPW'($signed(c[k][2*ELEM_W:ELEM_W]));
                t_reg[k]  <= (DTW'(ph_reg[k]) <<< ELEM_W) + DTW'(pl_reg[k]);
            end
            det_reg <= t_reg[0] + t_reg[1] + t_reg[2];
        end
    end

    assign det = det_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/mi3_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mi3_div import mi3_pkg::*; #(
    parameter int ELEM_W = ELEM_WIDTH_DEF,
    parameter int FRAC_B = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_v,
    input  wire logic [2*ELEM_W+2*FRAC_B-1:0]  num,
    input  wire logic [3*ELEM_W:0]             den,
    input  wire mi3_tag_t                      in_tag,
    output logic                               out_v,
    output logic [ELEM_W-1:0]                  quo,
    output logic                               big,
    output mi3_tag_t                           out_tag
);
    localparam int NW   = 2 * ELEM_W + 2 * FRAC_B;
    localparam int NHW  = NW - ELEM_W;
    localparam int DMW  = 3 * ELEM_W + 1;
    localparam int CMPW = (NHW > DMW) ? NHW : DMW;

    // input stage
    logic [NW-1:0]  num_reg;
    logic [DMW-1:0] den_in_reg;
    mi3_tag_t       tag_in_reg;
    logic           v_in_reg;

    // iteration stages, index 0 is the range check
    logic [DMW-1:0]    rem_reg  [0:ELEM_W];
    logic [DMW-1:0]    den_reg  [0:ELEM_W];
    logic [ELEM_W-1:0] nlo_reg  [0:ELEM_W];
    logic [ELEM_W-1:0] q_reg    [0:ELEM_W];
    logic              big_reg  [0:ELEM_W];
    mi3_tag_t          tag_reg  [0:ELEM_W];
    logic              v_reg    [0:ELEM_W];

    logic [NHW-1:0] nhi;
    assign nhi = num_reg[NW-1:ELEM_W];

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg <= 1'b0;
            for (int s = 0; s <= ELEM_W; s++) v_reg[s] <= 1'b0;
        end else if (en) begin
            v_in_reg <= in_v;
            v_reg[0] <= v_in_reg;
            for (int s = 1; s <= ELEM_W; s++) v_reg[s] <= v_reg[s-1];
        end
    end

    // quotient >= 2^ELEM_W exactly when the high part already reaches den
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= num;
            den_in_reg <= den;
            tag_in_reg <= in_tag;
            big_reg[0] <= CMPW'(nhi) >= CMPW'(den_in_reg);
            rem_reg[0] <= DMW'(nhi);
            den_reg[0] <= den_in_reg;
            nlo_reg[0] <= num_reg[ELEM_W-1:0];
            q_reg[0]   <= '0;
            tag_reg[0] <= tag_in_reg;
        end
    end

    // one shift-compare-subtract per stage
    for (genvar s = 1; s <= ELEM_W; s++) begin : g_stage
        logic [DMW:0] sh, diff;
        logic         ge;
        assign sh   = {rem_reg[s-1], nlo_reg[s-1][ELEM_W-1]};
        assign ge   = sh >= {1'b0, den_reg[s-1]};
        assign diff = sh - {1'b0, den_reg[s-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= ge ? diff[DMW-1:0] : sh[DMW-1:0];
                den_reg[s] <= den_reg[s-1];
                nlo_reg[s] <= {nlo_reg[s-1][ELEM_W-2:0], 1'b0};
                q_reg[s]   <= {q_reg[s-1][ELEM_W-2:0], ge};
                big_reg[s] <= big_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign out_v   = v_reg[ELEM_W];
    assign quo     = q_reg[ELEM_W];
    assign big     = big_reg[ELEM_W];
    assign out_tag = tag_reg[ELEM_W];
endmodule
`default_nettype wire

// ===== hw/rtl/mi3_collect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_collect
// Saturates quotients, gathers nine into a result, two-entry output queue.
// ----------------------------------------------------------------------------
module mi3_collect import mi3_pkg::*; #(
    parameter int ELEM_W = ELEM_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_v,
    input  wire logic [ELEM_W-1:0]             quo,
    input  wire logic                          big,
    input  wire mi3_tag_t                      tag,
    output logic                               adv,
    output logic                               out_v,
    input  wire logic                          out_rdy,
    output logic [NUM_ELEM*ELEM_W+1:0]         out_data
);
    localparam int RW = NUM_ELEM * ELEM_W + 2;

    logic [ELEM_W-1:0] lim, mag, val;
    logic              sat, sat_any, push, pop;
    logic [1:0]        st;
    logic [RW-1:0]     entry;
    logic [ELEM_W-1:0] elem_reg [0:NUM_ELEM-2];
    logic              sat_acc_reg;
    logic [RW-1:0]     q0_reg, q1_reg;
    logic [1:0]        cnt_reg;

    // clamp and sign
    always_comb begin
        lim     = tag.neg ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
        sat     = big || (quo > lim);
        mag     = sat ? lim : quo;
        val     = tag.sing ? '0 : (tag.neg ? -mag : mag);
        sat_any = sat_acc_reg || sat;
        st      = tag.sing ? ST_SING : (sat_any ? ST_SAT : ST_OK);
        for (int k = 0; k < NUM_ELEM - 1; k++) entry[k*ELEM_W +: ELEM_W] = elem_reg[k];
        entry[(NUM_ELEM-1)*ELEM_W +: ELEM_W] = val;
        entry[RW-1 -: 2] = st;
    end

    assign adv  = (cnt_reg != 2'd2) || out_rdy;
    assign push = adv && in_v && tag.last;
    assign pop  = out_v && out_rdy;

    // element shift line
    always_ff @(posedge aclk) begin
        if (adv && in_v) begin
            for (int k = 0; k < NUM_ELEM - 2; k++) elem_reg[k] <= elem_reg[k+1];
            elem_reg[NUM_ELEM-2] <= val;
        end
    end

    // saturation flag over one matrix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_acc_reg <= 1'b0;
        end else if (adv && in_v) begin
            sat_acc_reg <= tag.last ? 1'b0 : sat_any;
        end
    end

    // output queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                q0_reg <= entry;
            end else begin
                q0_reg <= q1_reg;
                q1_reg <= entry;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) q0_reg <= entry;
            else q1_reg <= entry;
        end else if (pop) begin
            q0_reg <= q1_reg;
        end
    end

    assign out_v    = cnt_reg != 2'd0;
    assign out_data = q0_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");
endmodule
`default_nettype wire
